// ===== rtl/core/boot_sequencer_with_retry_assert.svh =====
// assertion macros for the boot sequencer checker
// needs a clock and an active-low reset named by the caller
`ifndef BOOT_SEQUENCER_WITH_RETRY_ASSERT_SVH
`define BOOT_SEQUENCER_WITH_RETRY_ASSERT_SVH

// same-cycle implication, off while reset is low
`define BSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("boot sequencer check failed");

// next-cycle implication, off while reset is low
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("boot sequencer check failed");

`endif

// ===== rtl/core/bsr_pkg.sv =====
// shared types, codes and the transition table of the boot sequencer
// no dependencies
package bsr_pkg;

	// boot phases
	typedef enum logic [3:0] {
		PH_POWER_STAB   = 4'd0,
		PH_SYS_SETUP    = 4'd1,
		PH_USB_DEV_INIT = 4'd2,
		PH_CORE_START   = 4'd3,
		PH_WAIT_CORE    = 4'd4,
		PH_WDOG_START   = 4'd5,
		PH_POWER_EN     = 4'd6,
		PH_FINAL_CHECK  = 4'd7,
		PH_COMPLETE     = 4'd8,
		PH_ERROR        = 4'd9,
		PH_RETRY        = 4'd10
	} phase_t;

	// event codes, five to seven never match
	localparam logic [2:0] EV_TIMER      = 3'd0;
	localparam logic [2:0] EV_SUCCESS    = 3'd1;
	localparam logic [2:0] EV_FAILURE    = 3'd2;
	localparam logic [2:0] EV_CORE_READY = 3'd3;
	localparam logic [2:0] EV_RETRY_LIM  = 3'd4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_COLD_BOOT   = 3'd0,
		REG_USB_DEV     = 3'd1,
		REG_USB_STACK   = 3'd2,
		REG_PROGRESSIVE = 3'd3,
		REG_WATCHDOG    = 3'd4,
		REG_FINAL_STAB  = 3'd5,
		REG_POWER_EN    = 3'd6,
		REG_RETRY_LIMIT = 3'd7
	} reg_idx_t;

	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned CfgIndexW = 3;

	localparam logic [15:0] WAIT_RESET  = 16'd100;
	localparam logic [7:0]  LIMIT_RESET = 8'd3;
	localparam logic [7:0]  TALLY_MAX   = 8'hFF;

	// which register supplies the timeout of a new phase
	typedef enum logic [2:0] {
		WS_NONE,
		WS_COLD_BOOT,
		WS_USB_DEV,
		WS_USB_STACK,
		WS_PROGRESSIVE,
		WS_WATCHDOG,
		WS_FINAL_STAB,
		WS_POWER_EN
	} wait_sel_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [31:0] now_ms;
	} in_beat_t;

	typedef struct packed {
		logic       accepted;
		logic [3:0] state_now;
		logic [3:0] state_before;
		logic       is_complete;
		logic       is_error;
		logic [7:0] retries_used;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] cold_boot_wait;
		logic [15:0] usb_device_wait;
		logic [15:0] usb_stack_wait;
		logic [15:0] progressive_wait;
		logic [15:0] watchdog_wait;
		logic [15:0] final_stabilize_wait;
		logic [15:0] power_enable_wait;
		logic [7:0]  retry_limit;
	} cfg_bank_t;

	typedef struct packed {
		phase_t      phase;
		phase_t      prior;
		logic [31:0] stamp;
		logic [15:0] timeout;
		logic [7:0]  tally;
	} seq_state_t;

	typedef struct packed {
		logic      hit;
		phase_t    to;
		wait_sel_t sel;
	} edge_t;

	// fixed transition table
	function automatic edge_t edge_lookup(input phase_t ph, input logic [2:0] ev);
		edge_t e;
		e = '{hit: 1'b0, to: PH_POWER_STAB, sel: WS_NONE};
		unique case (ph)
			PH_POWER_STAB: begin
				if (ev == EV_TIMER) e = '{1'b1, PH_SYS_SETUP, WS_COLD_BOOT};
			end
			PH_SYS_SETUP: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_USB_DEV_INIT, WS_USB_DEV};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_ERROR, WS_NONE};
			end
			PH_USB_DEV_INIT: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_CORE_START, WS_USB_STACK};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_RETRY, WS_USB_STACK};
			end
			PH_CORE_START: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_WAIT_CORE, WS_PROGRESSIVE};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_RETRY, WS_PROGRESSIVE};
			end
			PH_WAIT_CORE: begin
				if (ev == EV_CORE_READY) e = '{1'b1, PH_WDOG_START, WS_WATCHDOG};
				else if (ev == EV_TIMER) e = '{1'b1, PH_RETRY, WS_PROGRESSIVE};
			end
			PH_WDOG_START: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_POWER_EN, WS_FINAL_STAB};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_RETRY, WS_PROGRESSIVE};
			end
			PH_POWER_EN: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_FINAL_CHECK, WS_POWER_EN};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_RETRY, WS_PROGRESSIVE};
			end
			PH_FINAL_CHECK: begin
				if (ev == EV_SUCCESS) e = '{1'b1, PH_COMPLETE, WS_NONE};
				else if (ev == EV_FAILURE) e = '{1'b1, PH_RETRY, WS_PROGRESSIVE};
			end
			PH_RETRY: begin
				if (ev == EV_TIMER) e = '{1'b1, PH_SYS_SETUP, WS_NONE};
				else if (ev == EV_RETRY_LIM) e = '{1'b1, PH_ERROR, WS_NONE};
			end
			default: begin
				e = '{hit: 1'b0, to: PH_POWER_STAB, sel: WS_NONE};
			end
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/core/bsr_regs.sv =====
// configuration register bank of the boot sequencer
// depends on bsr_pkg
module bsr_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [bsr_pkg::CfgIndexW-1:0]        cfg_index,
	input  logic [bsr_pkg::CfgDataW-1:0]         cfg_data,
	output bsr_pkg::cfg_bank_t                   bank
);
	import bsr_pkg::*;

	cfg_bank_t bank_q;
	reg_idx_t  idx;

	assign idx  = reg_idx_t'(cfg_index);
	assign bank = bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '{WAIT_RESET, WAIT_RESET, WAIT_RESET, WAIT_RESET,
				WAIT_RESET, WAIT_RESET, WAIT_RESET, LIMIT_RESET};
		end else if (cfg_write) begin
			unique case (idx)
				REG_COLD_BOOT:   bank_q.cold_boot_wait       <= cfg_data;
				REG_USB_DEV:     bank_q.usb_device_wait      <= cfg_data;
				REG_USB_STACK:   bank_q.usb_stack_wait       <= cfg_data;
				REG_PROGRESSIVE: bank_q.progressive_wait     <= cfg_data;
				REG_WATCHDOG:    bank_q.watchdog_wait        <= cfg_data;
				REG_FINAL_STAB:  bank_q.final_stabilize_wait <= cfg_data;
				REG_POWER_EN:    bank_q.power_enable_wait    <= cfg_data;
				REG_RETRY_LIMIT: bank_q.retry_limit          <= cfg_data[7:0];
				default:         bank_q                      <= bank_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/bsr_step.sv =====
// next-state logic for one event: timeout check, table lookup, retry count
// depends on bsr_pkg
module bsr_step (
	input  bsr_pkg::in_beat_t   beat,
	input  bsr_pkg::seq_state_t cur,
	input  bsr_pkg::cfg_bank_t  bank,
	output logic                hit,
	output bsr_pkg::seq_state_t nxt
);
	import bsr_pkg::*;

	logic [31:0] elapsed;
	logic        expired;
	logic [2:0]  ev_eff;
	edge_t       e;
	logic [15:0] wait_val;
	logic [7:0]  tally_inc;
	logic        from_retry;

	// elapsed time wraps modulo 2^32
	assign elapsed = beat.now_ms - cur.stamp;
	assign expired = (cur.timeout != 16'd0) && (elapsed >= {16'd0, cur.timeout});
	assign ev_eff  = expired ? EV_TIMER : beat.event_code;
	assign e       = edge_lookup(cur.phase, ev_eff);

	assign from_retry = (cur.phase == PH_RETRY);
	assign tally_inc  = (cur.tally == TALLY_MAX) ? TALLY_MAX : cur.tally + 8'd1;

	always_comb begin
		unique case (e.sel)
			WS_COLD_BOOT:   wait_val = bank.cold_boot_wait;
			WS_USB_DEV:     wait_val = bank.usb_device_wait;
			WS_USB_STACK:   wait_val = bank.usb_stack_wait;
			WS_PROGRESSIVE: wait_val = bank.progressive_wait;
			WS_WATCHDOG:    wait_val = bank.watchdog_wait;
			WS_FINAL_STAB:  wait_val = bank.final_stabilize_wait;
			WS_POWER_EN:    wait_val = bank.power_enable_wait;
			default:        wait_val = 16'd0;
		endcase
	end

	always_comb begin
		hit = e.hit;
		nxt = cur;
		if (e.hit) begin
			nxt.prior   = cur.phase;
			nxt.phase   = e.to;
			nxt.stamp   = beat.now_ms;
			nxt.timeout = wait_val;
			if (from_retry) begin
				nxt.tally = tally_inc;
				// give up once the limit is reached
				if (tally_inc >= bank.retry_limit) begin
					nxt.phase   = PH_ERROR;
					nxt.timeout = 16'd0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/boot_sequencer_with_retry.sv =====
// top level of the boot sequencer: handshake stages and sequence state
// depends on bsr_pkg, bsr_regs and bsr_step
//
// one event beat per clock sustained while out_ready stays high; a beat is
// held in an input register, resolved against the sequence state by a
// single pass of the timeout compare and the transition table, and its
// result beat is registered. the input side stays ready while a result
// waits as long as the input register is empty or moves on in the same
// cycle. every event gives exactly one result beat, with accepted low
// when the (phase, event) pair has no transition. the phase timeout is
// checked before the table: a nonzero timeout that has run out (now
// minus entry time, wrapping) turns the event into timer expired.
// configuration registers are written through a plain write port and
// only take effect on the next transition that loads them; write them
// while no event is in flight.
module boot_sequencer_with_retry (
	input  logic                          clk,
	input  logic                          arst_n,
	// event channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bsr_pkg::in_beat_t             in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output bsr_pkg::out_beat_t            out_data,
	// configuration writes
	input  logic                          cfg_write,
	input  logic [bsr_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [bsr_pkg::CfgDataW-1:0]  cfg_data
);
	import bsr_pkg::*;

	cfg_bank_t  bank;

	// input stage
	logic       valid_s1;
	in_beat_t   data_s1;

	// result stage
	logic       valid_s2;
	out_beat_t  data_s2;

	// sequence state
	seq_state_t state_q;
	seq_state_t state_nxt;
	logic       hit;

	// input stage advances when the result slot is free or being drained
	logic       advance;

	bsr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bank      (bank)
	);

	bsr_step u_step (
		.beat (data_s1),
		.cur  (state_q),
		.bank (bank),
		.hit  (hit),
		.nxt  (state_nxt)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// sequence state updates as each beat is resolved; a miss leaves it as is
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_POWER_STAB, prior: PH_POWER_STAB, stamp: 32'd0,
				timeout: WAIT_RESET, tally: 8'd0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2.accepted     <= hit;
			data_s2.state_now    <= state_nxt.phase;
			data_s2.state_before <= state_nxt.prior;
			data_s2.is_complete  <= (state_nxt.phase == PH_COMPLETE);
			data_s2.is_error     <= (state_nxt.phase == PH_ERROR);
			data_s2.retries_used <= state_nxt.tally;
		end
	end

endmodule

// ===== rtl/core/bsr_checker.sv =====
// port-level checks for the boot sequencer, bound to the top level
// depends on bsr_pkg and boot_sequencer_with_retry_assert.svh
`include "boot_sequencer_with_retry_assert.svh"

module bsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input bsr_pkg::out_beat_t            out_data,
	input logic                          cfg_write,
	input logic [bsr_pkg::CfgIndexW-1:0] cfg_index,
	input logic [bsr_pkg::CfgDataW-1:0]  cfg_data
);
	import bsr_pkg::*;

	logic        in_beat;
	logic        cfg_beat;
	logic [3:0]  complete_code;
	logic [3:0]  error_code;
	logic [3:0]  setup_code;
	logic [3:0]  stab_code;
	logic [3:0]  retry_code;

	assign in_beat       = in_valid && in_ready;
	assign cfg_beat      = cfg_write && (cfg_index == cfg_index) && (cfg_data == cfg_data);
	assign complete_code = PH_COMPLETE;
	assign error_code    = PH_ERROR;
	assign setup_code    = PH_SYS_SETUP;
	assign stab_code     = PH_POWER_STAB;
	assign retry_code    = PH_RETRY;

	// a stalled result beat holds
	`BSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// status flags follow the reported phase
	`BSR_ASSERT_NOW(a_flags, clk, arst_n, out_valid, (out_data.is_complete == (out_data.state_now == complete_code)) && (out_data.is_error == (out_data.state_now == error_code)))

	// the table has no self loops, so a taken move always changes the phase
	`BSR_ASSERT_NOW(a_moves, clk, arst_n, out_valid && out_data.accepted, out_data.state_now != out_data.state_before)

	// system setup is entered only from power stabilization or retry
	`BSR_ASSERT_NOW(a_setup_entry, clk, arst_n, out_valid && out_data.accepted && (out_data.state_now == setup_code), (out_data.state_before == stab_code) || (out_data.state_before == retry_code))

	// no result appears out of an idle stretch without an event having gone in before it
	`BSR_ASSERT_NEXT(a_no_spurious, clk, arst_n, !out_valid && !in_beat && !cfg_beat, ##1 !out_valid || $past(in_beat, 1) || $past(out_valid, 1))

endmodule

bind boot_sequencer_with_retry bsr_checker u_bsr_checker (.*);

// ===== test/boot_sequencer_with_retry_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the boot sequencer with retry
// depends on bsr_pkg and boot_sequencer_with_retry; drives events, predicts every result beat
module boot_sequencer_with_retry_tb;
	import bsr_pkg::*;

	// event codes with no transition anywhere
	localparam logic [2:0] EV_SPARE_5 = 3'd5;
	localparam logic [2:0] EV_SPARE_6 = 3'd6;
	localparam logic [2:0] EV_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BEATS = 370;
	localparam int CLOSING_BEATS = 80;

	// how the closing stretch of the run steers the sequence
	typedef enum logic [2:0] {
		FIN_NONE,
		FIN_COMPLETE,
		FIN_SETUP_FAIL,
		FIN_LIMIT_EVENT,
		FIN_TALLY
	} finale_t;

	typedef struct {
		in_beat_t  beat;
		bit        typed;
		out_beat_t want;
	} script_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;
	logic      cfg_write = 1'b0;
	reg_idx_t  cfg_index = REG_COLD_BOOT;
	logic [15:0] cfg_data = '0;

	boot_sequencer_with_retry uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the register bank
	logic [15:0] wait_regs [7] = '{default: WAIT_RESET};
	logic [7:0]  limit_reg = LIMIT_RESET;

	// shadow of the sequence state, as after reset
	phase_t      seq_phase = PH_POWER_STAB;
	phase_t      seq_prior = PH_POWER_STAB;
	logic [31:0] seq_stamp = '0;
	logic [15:0] seq_timeout = WAIT_RESET;
	logic [7:0]  seq_tally = '0;

	out_beat_t pending_results [$];
	out_beat_t head_result;
	int        fault_count = 0;
	int        results_seen = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	finale_t   finale = FIN_NONE;

	// long receiver hold-off, armed once from the main sequence
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// opening walk from reset with register reset values; typed rows are plain reads
	script_row_t boot_script [18] = '{
		// reset state, wrong event, no timeout yet
		'{'{EV_SUCCESS, 32'd0}, 1'b1, '{1'b0, PH_POWER_STAB, PH_POWER_STAB, 1'b0, 1'b0, 8'd0}},
		// unknown code one ms short of the timeout
		'{'{EV_SPARE_7, 32'd99}, 1'b1, '{1'b0, PH_POWER_STAB, PH_POWER_STAB, 1'b0, 1'b0, 8'd0}},
		// unknown code at the top of time, timeout long gone, becomes timer expired
		'{'{EV_SPARE_5, 32'hFFFF_FFFF}, 1'b1,
			'{1'b1, PH_SYS_SETUP, PH_POWER_STAB, 1'b0, 1'b0, 8'd0}},
		// elapsed time wraps through zero
		'{'{EV_SUCCESS, 32'd98}, 1'b0, '0},
		'{'{EV_CORE_READY, 32'd100}, 1'b0, '0},
		'{'{EV_FAILURE, 32'd150}, 1'b0, '0},
		// retry timeout runs out under a success event
		'{'{EV_SUCCESS, 32'd260}, 1'b0, '0},
		// zero timeout never expires
		'{'{EV_SPARE_6, 32'h8000_0000}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd300}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd310}, 1'b0, '0},
		'{'{EV_FAILURE, 32'd320}, 1'b0, '0},
		'{'{EV_TIMER, 32'd330}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd340}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd350}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd360}, 1'b0, '0},
		'{'{EV_RETRY_LIM, 32'd370}, 1'b0, '0},
		// second core too late, waiting phase expires into retry
		'{'{EV_CORE_READY, 32'd460}, 1'b0, '0},
		'{'{EV_SUCCESS, 32'd470}, 1'b0, '0}
	};

	function automatic string beat_text(input out_beat_t o);
		return $sformatf("acc=%0d state=%0d prior=%0d done=%0d err=%0d retries=%0d",
			o.accepted, o.state_now, o.state_before, o.is_complete, o.is_error,
			o.retries_used);
	endfunction

	// one step of the boot sequence: timeout check, table lookup, retry accounting
	function automatic out_beat_t advance_sequence(input in_beat_t b);
		logic [2:0]  code;
		phase_t      dest;
		reg_idx_t    src;
		bit          no_wait;
		bit          hit;
		logic [15:0] load;
		out_beat_t   r;
		code = b.event_code;
		// an expired phase turns any event into timer expired
		if (code != EV_TIMER && seq_timeout != '0 && (b.now_ms - seq_stamp) >= seq_timeout)
			code = EV_TIMER;
		dest = seq_phase;
		src = REG_COLD_BOOT;
		no_wait = 1'b0;
		case (seq_phase)
			PH_POWER_STAB: begin
				if (code == EV_TIMER) dest = PH_SYS_SETUP;
			end
			PH_SYS_SETUP: begin
				src = REG_USB_DEV;
				if (code == EV_SUCCESS) dest = PH_USB_DEV_INIT;
				if (code == EV_FAILURE) begin
					dest = PH_ERROR;
					no_wait = 1'b1;
				end
			end
			PH_USB_DEV_INIT: begin
				// both ways out load the usb stack wait
				src = REG_USB_STACK;
				if (code == EV_SUCCESS) dest = PH_CORE_START;
				if (code == EV_FAILURE) dest = PH_RETRY;
			end
			PH_CORE_START: begin
				src = REG_PROGRESSIVE;
				if (code == EV_SUCCESS) dest = PH_WAIT_CORE;
				if (code == EV_FAILURE) dest = PH_RETRY;
			end
			PH_WAIT_CORE: begin
				src = (code == EV_CORE_READY) ? REG_WATCHDOG : REG_PROGRESSIVE;
				if (code == EV_CORE_READY) dest = PH_WDOG_START;
				if (code == EV_TIMER) dest = PH_RETRY;
			end
			PH_WDOG_START: begin
				src = (code == EV_SUCCESS) ? REG_FINAL_STAB : REG_PROGRESSIVE;
				if (code == EV_SUCCESS) dest = PH_POWER_EN;
				if (code == EV_FAILURE) dest = PH_RETRY;
			end
			PH_POWER_EN: begin
				src = (code == EV_SUCCESS) ? REG_POWER_EN : REG_PROGRESSIVE;
				if (code == EV_SUCCESS) dest = PH_FINAL_CHECK;
				if (code == EV_FAILURE) dest = PH_RETRY;
			end
			PH_FINAL_CHECK: begin
				src = REG_PROGRESSIVE;
				no_wait = (code == EV_SUCCESS);
				if (code == EV_SUCCESS) dest = PH_COMPLETE;
				if (code == EV_FAILURE) dest = PH_RETRY;
			end
			PH_RETRY: begin
				no_wait = 1'b1;
				if (code == EV_TIMER) dest = PH_SYS_SETUP;
				if (code == EV_RETRY_LIM) dest = PH_ERROR;
			end
			default: begin
				// complete and error are dead ends
			end
		endcase
		// no transition leads back to its own phase
		hit = (dest != seq_phase);
		if (hit) begin
			load = no_wait ? 16'd0 : wait_regs[src];
			if (seq_phase == PH_RETRY) begin
				if (seq_tally != TALLY_MAX) seq_tally = seq_tally + 8'd1;
				// limit reached overrides the table target
				if (seq_tally >= limit_reg) begin
					dest = PH_ERROR;
					load = '0;
				end
			end
			seq_prior = seq_phase;
			seq_phase = dest;
			seq_stamp = b.now_ms;
			seq_timeout = load;
		end
		r.accepted = hit;
		r.state_now = seq_phase;
		r.state_before = seq_prior;
		r.is_complete = (seq_phase == PH_COMPLETE);
		r.is_error = (seq_phase == PH_ERROR);
		r.retries_used = seq_tally;
		return r;
	endfunction

	// next event: mostly the move that keeps the boot going, with random timing
	function automatic in_beat_t compose_event();
		in_beat_t    b;
		logic [31:0] lag;
		bit          fail;
		bit          stuck;
		int          pick;
		b.event_code = 3'($urandom_range(EV_SPARE_7));
		b.now_ms = $urandom();
		// retry exit would hit the limit, so sit in retry during the main stretch
		stuck = (finale == FIN_NONE && seq_phase == PH_RETRY && seq_tally + 1 >= limit_reg);
		if (stuck) begin
			b.event_code = EV_SUCCESS;
			b.now_ms = seq_stamp;
			return b;
		end
		// noise beat; during the main stretch it must not end the sequence
		if ($urandom_range(99) < 20) begin
			if (finale == FIN_NONE &&
				((seq_phase == PH_SYS_SETUP && b.event_code == EV_FAILURE) ||
				(seq_phase == PH_FINAL_CHECK && b.event_code == EV_SUCCESS) ||
				(seq_phase == PH_RETRY && b.event_code == EV_RETRY_LIM)))
				b.event_code = EV_SPARE_5;
			return b;
		end
		fail = (finale == FIN_NONE) ? ($urandom_range(99) < 8) : (finale != FIN_COMPLETE);
		case (seq_phase)
			PH_POWER_STAB: b.event_code = EV_TIMER;
			PH_SYS_SETUP: b.event_code = (finale == FIN_SETUP_FAIL) ? EV_FAILURE : EV_SUCCESS;
			PH_WAIT_CORE: b.event_code = fail ? EV_TIMER : EV_CORE_READY;
			PH_FINAL_CHECK: b.event_code = (finale == FIN_COMPLETE) ? EV_SUCCESS : EV_FAILURE;
			PH_RETRY: b.event_code = (finale == FIN_LIMIT_EVENT) ? EV_RETRY_LIM : EV_TIMER;
			PH_COMPLETE, PH_ERROR: begin
				// any code, nothing moves any more
			end
			default: b.event_code = fail ? EV_FAILURE : EV_SUCCESS;
		endcase
		// time since phase entry: mostly inside the timeout, sometimes on or past it
		pick = $urandom_range(99);
		if (seq_timeout == '0 || pick < 6)
			lag = $urandom();
		else if (pick < 14)
			lag = seq_timeout + $urandom_range(1) - 1;
		else
			lag = $urandom_range(seq_timeout - 1);
		b.now_ms = seq_stamp + lag;
		return b;
	endfunction

	// offer one event beat, predict its result once it is taken
	task automatic offer_event(input in_beat_t b, input bit typed, input out_beat_t want);
		out_beat_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		predicted = advance_sequence(b);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// stop offering and let every result beat come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all eight registers while idle; waits drawn with zero and all-ones favored
	task automatic program_registers(input logic [7:0] limit);
		int          pick;
		logic [15:0] word;
		drain();
		for (int i = 0; i < 8; i++) begin
			pick = $urandom_range(99);
			if (reg_idx_t'(i) == REG_RETRY_LIMIT)
				word = {8'($urandom_range(255)), limit};
			else if (pick < 15)
				word = '0;
			else if (pick < 25)
				word = '1;
			else if (pick < 75)
				word = 16'($urandom_range(300, 1));
			else
				word = 16'($urandom());
			cfg_write <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= word;
			@(posedge clk);
			// upper byte of the limit write is dropped
			if (reg_idx_t'(i) == REG_RETRY_LIMIT)
				limit_reg = word[7:0];
			else
				wait_regs[i] = word;
		end
		cfg_write <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result beat %0d with nothing expected: %s", results_seen,
						beat_text(out_data));
			end else begin
				head_result = pending_results.pop_front();
				if (out_data !== head_result) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result beat %0d mismatch\n  expected %s\n  actual   %s",
							results_seen, beat_text(head_result), beat_text(out_data));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("boot_sequencer_with_retry_tb failed");
			$finish;
		end
	end

	int send_pcts [4] = '{0, 68, 0, 23};
	int recv_pcts [4] = '{0, 0, 68, 23};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk from reset values
		foreach (boot_script[i])
			offer_event(boot_script[i].beat, boot_script[i].typed, boot_script[i].want);

		// random phases, registers reloaded before each
		for (int p = 0; p < 4; p++) begin
			if (p == 1)
				program_registers(8'($urandom_range(255,
					(seq_tally > 105) ? 255 : seq_tally + 150)));
			else
				program_registers(8'd255);
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// sender keeps going through the hold-off so the block backs up
				if (p == 2 && n == 60) hold_request <= 1'b1;
				offer_event(compose_event(), 1'b0, '0);
			end
		end

		// closing stretch: steer into complete or one of the error paths
		finale = finale_t'($urandom_range(FIN_TALLY, FIN_COMPLETE));
		program_registers((finale == FIN_TALLY) ? 8'($urandom_range(1)) : 8'd255);
		send_idle_pct = 23;
		recv_stall_pct = 23;
		for (int n = 0; n < CLOSING_BEATS; n++)
			offer_event(compose_event(), 1'b0, '0);

		drain();
		if (fault_count == 0)
			$display("boot_sequencer_with_retry_tb passed");
		else
			$display("boot_sequencer_with_retry_tb failed");
		$finish;
	end

endmodule
